/* src/icchp_pkg.sv */
package icchp_pkg;

	// header geometry
	localparam int unsigned HeaderBytes = 128;
	localparam int unsigned PosW = 7;
	localparam int unsigned CountW = 8;
	localparam logic [CountW-1:0] HEADER_LEN = CountW'(HeaderBytes);

	// fixed signature strings
	localparam logic [95:0] SIG_DEVICE = "mntrRGB XYZ ";
	localparam logic [31:0] SIG_FILE = "acsp";

	// fixed header constants
	localparam logic [7:0] VERSION_MAJOR = 8'd4;
	localparam logic [7:0] ILLUM_70 = 8'd246;
	localparam logic [7:0] ILLUM_71 = 8'd214;
	localparam logic [7:0] ILLUM_73 = 8'd1;
	localparam logic [7:0] ILLUM_78 = 8'd211;
	localparam logic [7:0] ILLUM_79 = 8'd45;

	// positions of bytes that later predictions depend on
	localparam logic [PosW-1:0] POS_PLATFORM0 = 7'd40;
	localparam logic [PosW-1:0] POS_PLATFORM1 = 7'd41;

	// decoded bytes 4..7, reused at positions 80..83
	typedef logic [3:0][7:0] size_copy_t;

	// platform tag guess for positions 41..43
	function automatic logic [7:0] platform_guess(
		input logic [PosW-1:0] pos,
		input logic [7:0] c40,
		input logic [7:0] c41
	);
		logic [7:0] res;
		res = 8'd0;
		if (c40 == "A") begin
			res = (pos == 7'd43) ? "L" : "P";
		end else if (c40 == "M") begin
			res = (pos == 7'd41) ? "S" : ((pos == 7'd42) ? "F" : "T");
		end else if (c40 == "S" && pos != 7'd41) begin
			if (c41 == "G") begin
				res = (pos == 7'd42) ? "I" : " ";
			end else if (c41 == "U") begin
				res = (pos == 7'd42) ? "N" : "W";
			end
		end
		return res;
	endfunction

	// predicted byte for a header position
	function automatic logic [7:0] predict(
		input logic [PosW-1:0] pos,
		input logic [31:0] size,
		input size_copy_t copy,
		input logic [7:0] c40,
		input logic [7:0] c41
	);
		logic [7:0] res;
		res = 8'd0;
		case (pos)
			7'd0: res = size[31:24];
			7'd1: res = size[23:16];
			7'd2: res = size[15:8];
			7'd3: res = size[7:0];
			7'd8: res = VERSION_MAJOR;
			7'd12: res = SIG_DEVICE[95:88];
			7'd13: res = SIG_DEVICE[87:80];
			7'd14: res = SIG_DEVICE[79:72];
			7'd15: res = SIG_DEVICE[71:64];
			7'd16: res = SIG_DEVICE[63:56];
			7'd17: res = SIG_DEVICE[55:48];
			7'd18: res = SIG_DEVICE[47:40];
			7'd19: res = SIG_DEVICE[39:32];
			7'd20: res = SIG_DEVICE[31:24];
			7'd21: res = SIG_DEVICE[23:16];
			7'd22: res = SIG_DEVICE[15:8];
			7'd23: res = SIG_DEVICE[7:0];
			7'd36: res = SIG_FILE[31:24];
			7'd37: res = SIG_FILE[23:16];
			7'd38: res = SIG_FILE[15:8];
			7'd39: res = SIG_FILE[7:0];
			7'd41, 7'd42, 7'd43: res = platform_guess(pos, c40, c41);
			7'd70: res = ILLUM_70;
			7'd71: res = ILLUM_71;
			7'd73: res = ILLUM_73;
			7'd78: res = ILLUM_78;
			7'd79: res = ILLUM_79;
			7'd80: res = copy[0];
			7'd81: res = copy[1];
			7'd82: res = copy[2];
			7'd83: res = copy[3];
			default: res = 8'd0;
		endcase
		return res;
	endfunction

endpackage

/* src/icc_header_predictor_core.sv */
// latency: a result appears in the cycle after its byte is accepted
// throughput: one byte per cycle while the output is not stalled, set by the single result register
// header length is min(128, profile_size); bytes beyond it are taken and dropped
// reset clears the position count, the size register and the result valid;
// the kept header bytes hold no reset value and are written before use
module icc_header_predictor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  residual_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  header_byte,
	output logic [6:0]  position,
	output logic        last_byte
);

	logic [31:0] size_q;
	logic [icchp_pkg::CountW-1:0] pos_q;
	icchp_pkg::size_copy_t copy_q;
	logic [7:0] c40_q;
	logic [7:0] c41_q;
	logic out_valid_q;
	logic [7:0] header_byte_q;
	logic [6:0] position_q;
	logic last_byte_q;

	logic cfg_wr;
	logic in_acc;
	logic active;
	logic [icchp_pkg::CountW-1:0] len;
	logic [icchp_pkg::PosW-1:0] pos_idx;
	logic [7:0] pred;
	logic [7:0] dec_byte;

	// handshakes
	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid & cfg_ready;
	assign in_stall = out_valid_q & out_stall;
	assign in_acc = in_valid & ~in_stall;

	// header length and prediction
	assign len = (size_q < 32'(icchp_pkg::HeaderBytes)) ? size_q[icchp_pkg::CountW-1:0]
		: icchp_pkg::HEADER_LEN;
	assign active = pos_q < len;
	assign pos_idx = pos_q[icchp_pkg::PosW-1:0];
	assign pred = icchp_pkg::predict(pos_idx, size_q, copy_q, c40_q, c41_q);
	assign dec_byte = pred + residual_byte;

	// size register and position count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
			pos_q <= '0;
		end else if (cfg_wr) begin
			size_q <= cfg_data;
			pos_q <= '0;
		end else if (in_acc && active) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// kept header bytes for later predictions
	always_ff @(posedge clk) begin
		if (in_acc && active) begin
			if (pos_idx[icchp_pkg::PosW-1:2] == 5'd1) begin
				copy_q[pos_idx[1:0]] <= dec_byte;
			end
			if (pos_idx == icchp_pkg::POS_PLATFORM0) begin
				c40_q <= dec_byte;
			end
			if (pos_idx == icchp_pkg::POS_PLATFORM1) begin
				c41_q <= dec_byte;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= active;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_acc && active) begin
			header_byte_q <= dec_byte;
			position_q <= pos_idx;
			last_byte_q <= (pos_q + 1'b1) == len;
		end
	end

	assign out_valid = out_valid_q;
	assign header_byte = header_byte_q;
	assign position = position_q;
	assign last_byte = last_byte_q;

	// count never runs past the header
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= icchp_pkg::HEADER_LEN)
		else $error("position count beyond header");

	// a size write restarts the count
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> pos_q == '0)
		else $error("size write did not restart count");

	// an accepted header byte produces a result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && active |=> out_valid_q && position_q == $past(pos_idx))
		else $error("missing result for header byte");

	// bytes past the header leave the count alone
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && !active && !cfg_wr |=> $stable(pos_q) && !out_valid_q)
		else $error("byte past header changed state");

endmodule

/* sim/tb_icc_header_predictor_core.sv */
module tb_icc_header_predictor_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned HDR_MAX = 128;
	localparam logic [95:0] DEVICE_SIG = "mntrRGB XYZ ";
	localparam logic [31:0] FILE_SIG = "acsp";

	typedef struct {
		logic [7:0] hbyte;
		logic [6:0] pos;
		logic       last;
	} hdr_entry_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #5 clk = ~clk;

	// block ports
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  residual_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  header_byte;
	logic [6:0]  position;
	logic        last_byte;

	icc_header_predictor_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.residual_byte(residual_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.header_byte  (header_byte),
		.position     (position),
		.last_byte    (last_byte)
	);

	// predictor state
	logic [31:0] dec_size = '0;
	logic [7:0]  dec_pos = '0;
	logic [7:0]  dec_kept [6];
	hdr_entry_t  header_q [$];

	// run bookkeeping
	int unsigned mismatches = 0;
	int unsigned results_checked = 0;
	int unsigned bytes_sent = 0;
	int unsigned size_writes = 0;
	int unsigned tag_hits [4] = '{0, 0, 0, 0};
	bit          quiet = 1'b0;
	bit          sink_hold = 1'b0;
	int unsigned sink_wait = 0;

	function automatic int unsigned draw_gap();
		return quiet ? 0 : $urandom_range(15, 0);
	endfunction

	function automatic int unsigned header_len();
		return (dec_size < HDR_MAX) ? dec_size : HDR_MAX;
	endfunction

	// predicted byte for header position i from the decoded state
	function automatic logic [7:0] predict_header_byte(input int unsigned i);
		logic [7:0] c40;
		logic [7:0] c41;
		c40 = dec_kept[4];
		c41 = dec_kept[5];
		if (i <= 3) return dec_size[8*(3-i) +: 8];
		if (i == 8) return 8'd4;
		if (i >= 12 && i <= 23) return DEVICE_SIG[8*(23-i) +: 8];
		if (i >= 36 && i <= 39) return FILE_SIG[8*(39-i) +: 8];
		if (i >= 41 && i <= 43) begin
			if (c40 == "A") return (i == 43) ? "L" : "P";
			if (c40 == "M") return (i == 41) ? "S" : ((i == 42) ? "F" : "T");
			if (c40 == "S" && i != 41) begin
				if (c41 == "G") return (i == 42) ? "I" : " ";
				if (c41 == "U") return (i == 42) ? "N" : "W";
			end
			return 8'd0;
		end
		// illuminant and rendering constants
		if (i == 70) return 8'd246;
		if (i == 71) return 8'd214;
		if (i == 73) return 8'd1;
		if (i == 78) return 8'd211;
		if (i == 79) return 8'd45;
		if (i >= 80 && i <= 83) return dec_kept[i-80];
		return 8'd0;
	endfunction

	// advance the predictor by one accepted residual
	function automatic void decode_residual(input logic [7:0] r);
		int unsigned len;
		int unsigned i;
		logic [7:0] b;
		hdr_entry_t e;
		len = header_len();
		i = dec_pos;
		if (i >= len) return;
		b = predict_header_byte(i) + r;
		if (i >= 4 && i <= 7) dec_kept[i-4] = b;
		else if (i == 40) dec_kept[4] = b;
		else if (i == 41) begin
			dec_kept[5] = b;
			if (dec_kept[4] == "A") tag_hits[0]++;
			else if (dec_kept[4] == "M") tag_hits[1]++;
			else if (dec_kept[4] == "S" && b == "G") tag_hits[2]++;
			else if (dec_kept[4] == "S" && b == "U") tag_hits[3]++;
		end
		e.hbyte = b;
		e.pos = i[6:0];
		e.last = (i + 1 == len);
		header_q.push_back(e);
		dec_pos = 8'(i + 1);
	endfunction

	// offer one residual after a random gap, keep valid high once accepted
	task automatic send_residual(input logic [7:0] b);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		residual_byte <= b;
		do @(posedge clk); while (in_stall);
		decode_residual(b);
		bytes_sent++;
	endtask

	// let every pending result come out and the pipeline go quiet
	task automatic wait_settled();
		in_valid <= 1'b0;
		while (header_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_profile_size(input logic [31:0] v);
		wait_settled();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dec_size = v;
		dec_pos = '0;
		size_writes++;
	endtask

	// one header: tag0/tag1 force decoded bytes 40/41 when nonzero,
	// other bytes decode to the prediction unless noise picks a random residual
	task automatic run_header(input logic [31:0] size, input logic [7:0] tag0,
			input logic [7:0] tag1, input int unsigned count, input int unsigned noise_pct);
		logic [7:0] res;
		write_profile_size(size);
		for (int unsigned k = 0; k < count; k++) begin
			if (k == 40 && tag0 != 8'd0)
				res = tag0 - predict_header_byte(k);
			else if (k == 41 && tag1 != 8'd0)
				res = tag1 - predict_header_byte(k);
			else if ($urandom_range(99, 0) < noise_pct)
				res = 8'($urandom_range(255, 0));
			else
				res = 8'd0;
			send_residual(res);
		end
	endtask

	// result sink: random stall per transaction, plus the long hold-off
	always @(posedge clk) begin : result_sink
		int unsigned next_wait;
		next_wait = sink_wait;
		if (out_valid && !out_stall) next_wait = draw_gap();
		else if (next_wait > 0) next_wait--;
		sink_wait <= next_wait;
		out_stall <= sink_hold || (next_wait > 0);
	end

	// compare each result transaction with the oldest expectation
	always @(posedge clk) begin : result_check
		hdr_entry_t exp_e;
		if (arst_n && out_valid && !out_stall) begin
			if (header_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: byte %02h pos %0d last %0b",
						header_byte, position, last_byte);
			end else begin
				exp_e = header_q.pop_front();
				results_checked++;
				if (exp_e.hbyte !== header_byte || exp_e.pos !== position ||
						exp_e.last !== last_byte) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %02h/%0d/%0b got %02h/%0d/%0b",
							exp_e.hbyte, exp_e.pos, exp_e.last,
							header_byte, position, last_byte);
				end
			end
		end
	end

	// residual extremes, wraparound of the sum, bytes past a short header
	task automatic test_byte_extremes();
		write_profile_size(32'd4);
		send_residual(8'h00);
		send_residual(8'hFF);
		send_residual(8'h80);
		send_residual(8'h7F);
		send_residual(8'hA5);
		write_profile_size(32'hFFFF_FFFF);
		send_residual(8'h01);
		send_residual(8'h00);
		send_residual(8'hFF);
		send_residual(8'h80);
	endtask

	// empty header: nothing comes out
	task automatic test_zero_size();
		write_profile_size(32'd0);
		send_residual(8'h12);
		send_residual(8'hFF);
		send_residual(8'h00);
	endtask

	// one byte header, then a dropped byte
	task automatic test_single_byte();
		write_profile_size(32'd1);
		send_residual(8'h5A);
		send_residual(8'hC3);
	endtask

	// size write in the middle of a header restarts the count
	task automatic test_restart();
		write_profile_size(32'd3);
		send_residual(8'h11);
		send_residual(8'h22);
		write_profile_size(32'd3);
		send_residual(8'h33);
		send_residual(8'h44);
		send_residual(8'h55);
	endtask

	// every platform prefix plus unknown ones, through the copied size bytes
	task automatic test_platform_tags();
		run_header(32'd84, "A", 8'd0, 84, 0);
		run_header(32'd84, "M", 8'd0, 84, 0);
		run_header(32'd84, "S", "G", 84, 0);
		run_header(32'd84, "S", "U", 84, 0);
		run_header(32'd84, "S", "Q", 84, 10);
		run_header(32'd84, "X", 8'd0, 84, 10);
		run_header(32'd128, "A", 8'd0, 130, 20);
		run_header(32'd129, "M", 8'd0, 129, 5);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		wait_settled();
		quiet = 1'b1;
		fork
			begin
				sink_hold <= 1'b1;
				repeat (300) @(posedge clk);
				sink_hold <= 1'b0;
			end
			run_header(32'd128, "S", "U", 130, 30);
		join
		quiet = 1'b0;
	endtask

	// mostly well formed headers with random sizes and tags, some noise and cuts
	task automatic test_random_headers();
		int unsigned goal;
		int unsigned pick;
		int unsigned len;
		int unsigned count;
		int unsigned noise;
		logic [31:0] size;
		logic [7:0] t0;
		logic [7:0] t1;
		goal = 1500;
		while (bytes_sent < goal) begin
			pick = $urandom_range(19, 0);
			if (pick < 12) size = $urandom_range(127, 1);
			else if (pick < 15) size = 32'd128;
			else if (pick < 18) size = $urandom;
			else if (pick == 18) size = 32'd0;
			else size = $urandom_range(130, 129);
			len = (size < HDR_MAX) ? size : HDR_MAX;
			count = (size == 0) ? $urandom_range(3, 1) : len + $urandom_range(3, 0);
			if ($urandom_range(7, 0) == 0) count = $urandom_range(count, 1);
			case ($urandom_range(4, 0))
				0: t0 = "A";
				1: t0 = "M";
				2, 3: t0 = "S";
				default: t0 = 8'($urandom_range(255, 1));
			endcase
			t1 = 8'd0;
			if (t0 == "S") begin
				case ($urandom_range(2, 0))
					0: t1 = "G";
					1: t1 = "U";
					default: t1 = 8'($urandom_range(255, 1));
				endcase
			end
			noise = ($urandom_range(4, 0) == 0) ? 100 : 12;
			quiet = ($urandom_range(4, 0) == 0);
			run_header(size, t0, t1, count, noise);
		end
		quiet = 1'b0;
	endtask

	initial begin : main_seq
		foreach (dec_kept[k]) dec_kept[k] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_byte_extremes();
		test_zero_size();
		test_single_byte();
		test_restart();
		test_platform_tags();
		test_backpressure();
		test_random_headers();
		wait_settled();
		repeat (10) @(posedge clk);
		mismatches += header_q.size();
		$display("run covered %0d residuals, %0d checked header bytes, %0d size writes",
			bytes_sent, results_checked, size_writes);
		$display("platform prefixes decoded: APPL %0d, MSFT %0d, SGI %0d, SUNW %0d",
			tag_hits[0], tag_hits[1], tag_hits[2], tag_hits[3]);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// watchdog
	initial begin : watchdog
		#(3_000_000);
		$display("timeout with %0d results outstanding", header_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
